// ===== sv/nau_pkg.sv =====
package nau_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int DATA_WIDTH   = 16;
    localparam int TAYLOR_TERMS = 13;
    localparam int EXP_STEPS    = 31;
    localparam int DIV_STEPS    = 31;
    localparam int LOG_STEPS    = 30;

    localparam logic [30:0] ONE30            = 31'h4000_0000;
    localparam logic [28:0] INV_E_Q30        = 29'd395007542;
    localparam logic [29:0] LN2_Q30          = 30'd744261118;
    localparam logic [28:0] INV_SQRT_2PI_Q30 = 29'd428361012;

    localparam logic [3:0] CMD_SIGMOID    = 4'd0;
    localparam logic [3:0] CMD_TANH       = 4'd1;
    localparam logic [3:0] CMD_RELU       = 4'd2;
    localparam logic [3:0] CMD_LEAKY      = 4'd3;
    localparam logic [3:0] CMD_SOFTPLUS   = 4'd4;
    localparam logic [3:0] CMD_SOFTMAX    = 4'd5;
    localparam logic [3:0] CMD_GAUSS      = 4'd6;
    localparam logic [3:0] CMD_D_SIGMOID  = 4'd7;
    localparam logic [3:0] CMD_D_TANH     = 4'd8;
    localparam logic [3:0] CMD_D_RELU     = 4'd9;
    localparam logic [3:0] CMD_D_LEAKY    = 4'd10;
    localparam logic [3:0] CMD_D_SOFTPLUS = 4'd11;
    localparam logic [3:0] CMD_D_SOFTMAX  = 4'd12;
    localparam logic [3:0] CMD_D_GAUSS    = 4'd13;

    typedef struct packed {
        logic [3:0]                   command;
        logic signed [DATA_WIDTH-1:0] sample;
    } nau_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         bad_command;
    } nau_out_t;

    typedef struct packed {
        nau_in_t     item;
        logic [5:0]  k;
        logic [29:0] f;
    } nau_arg_t;

    typedef struct packed {
        nau_in_t     item;
        logic [30:0] e;
    } nau_exp_t;

    typedef struct packed {
        nau_in_t     item;
        logic [30:0] e;
        logic [30:0] q;
        logic [30:0] l;
    } nau_dl_t;

endpackage

// ===== sv/nau_front.sv =====
module nau_front
    import nau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  nau_in_t  in_item,
    output logic     arg_valid,
    output nau_arg_t arg
);

    logic signed [16:0] sx;
    logic [16:0]        ax;
    logic [33:0]        ax2_full;
    logic [30:0]        ax2;
    nau_arg_t           arg_next;
    nau_arg_t           arg_reg;
    logic               valid_reg;

    always_comb
    begin
        sx       = 17'(in_item.sample);
        ax       = sx[16] ? 17'(-sx) : 17'(sx);
        ax2_full = {17'd0, ax} * {17'd0, ax};
        ax2      = ax2_full[30:0];
        arg_next.item = in_item;
        case (in_item.command)
            CMD_GAUSS, CMD_D_GAUSS:
            begin
                arg_next.k = ax2[30:25];
                arg_next.f = {ax2[24:0], 5'd0};
            end
            CMD_TANH, CMD_D_TANH:
            begin
                arg_next.k = ax[16:11];
                arg_next.f = {ax[10:0], 19'd0};
            end
            default:
            begin
                arg_next.k = {1'b0, ax[16:12]};
                arg_next.f = {ax[11:0], 18'd0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            arg_reg <= arg_next;
    end

    assign arg_valid = valid_reg;
    assign arg       = arg_reg;

endmodule

// ===== sv/nau_exp.sv =====
module nau_exp
    import nau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     arg_valid,
    input  nau_arg_t arg,
    output logic     exp_valid,
    output nau_exp_t exp_res
);

    localparam int TAY_STAGES = 3 * TAYLOR_TERMS;

    typedef struct packed {
        nau_in_t     item;
        logic [5:0]  k;
        logic [29:0] f;
        logic [62:0] acc;
        logic [30:0] term;
        logic [31:0] sum;
    } tay_t;

    typedef struct packed {
        nau_in_t     item;
        logic [5:0]  k;
        logic [30:0] r;
    } pow_t;

    tay_t tay_reg     [TAY_STAGES];
    logic tay_vld_reg [TAY_STAGES];
    pow_t pow_reg     [EXP_STEPS];
    logic pow_vld_reg [EXP_STEPS];
    tay_t tay_in;
    pow_t pow_in;

    always_comb
    begin
        tay_in.item = arg.item;
        tay_in.k    = arg.k;
        tay_in.f    = arg.f;
        tay_in.acc  = '0;
        tay_in.term = ONE30;
        tay_in.sum  = 32'(ONE30);
        pow_in.item = tay_reg[TAY_STAGES-1].item;
        pow_in.k    = tay_reg[TAY_STAGES-1].k;
        pow_in.r    = tay_reg[TAY_STAGES-1].sum[30:0];
    end

    for (genvar g = 0; g < TAY_STAGES; g++)
    begin : g_tay
        localparam int N     = g / 3 + 1;
        localparam int PHASE = g % 3;
        tay_t src;
        tay_t tay_next;
        logic src_vld;

        if (g == 0)
        begin : g_first
            assign src     = tay_in;
            assign src_vld = arg_valid;
        end
        else
        begin : g_chain
            assign src     = tay_reg[g-1];
            assign src_vld = tay_vld_reg[g-1];
        end

        if (PHASE == 0)
        begin : g_mul
            logic [60:0] prod;
            always_comb
            begin
                prod          = 61'(src.term) * 61'(src.f);
                tay_next      = src;
                tay_next.term = prod[60:30];
            end
        end
        else if (PHASE == 1)
        begin : g_recip
            localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
            always_comb
            begin
                tay_next     = src;
                tay_next.acc = 63'(src.term[29:0]) * 63'(RECIP);
            end
        end
        else
        begin : g_fix
            logic [29:0] q0;
            logic [33:0] qn;
            logic [30:0] rem;
            logic [30:0] q;
            always_comb
            begin
                q0  = src.acc[61:32];
                qn  = 34'(q0) * 34'(N);
                rem = src.term - qn[30:0];
                q   = (rem >= 31'(N)) ? 31'(q0) + 31'd1 : 31'(q0);
                tay_next      = src;
                tay_next.term = q;
                if (N % 2 == 1)
                    tay_next.sum = src.sum - 32'(q);
                else
                    tay_next.sum = src.sum + 32'(q);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tay_vld_reg[g] <= 1'b0;
            else if (en)
                tay_vld_reg[g] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                tay_reg[g] <= tay_next;
        end
    end

    for (genvar i = 0; i < EXP_STEPS; i++)
    begin : g_pow
        pow_t        src;
        pow_t        pow_next;
        logic        src_vld;
        logic [59:0] prod;
        logic [60:0] rsum;

        if (i == 0)
        begin : g_first
            assign src     = pow_in;
            assign src_vld = tay_vld_reg[TAY_STAGES-1];
        end
        else
        begin : g_chain
            assign src     = pow_reg[i-1];
            assign src_vld = pow_vld_reg[i-1];
        end

        always_comb
        begin
            prod     = 60'(src.r) * 60'(INV_E_Q30);
            rsum     = {1'b0, prod} + 61'(ONE30 >> 1);
            pow_next = src;
            if (src.k > 6'(i))
                pow_next.r = rsum[60:30];
            if (i == EXP_STEPS - 1 && src.k[5])
                pow_next.r = '0;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pow_vld_reg[i] <= 1'b0;
            else if (en)
                pow_vld_reg[i] <= src_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                pow_reg[i] <= pow_next;
        end
    end

    assign exp_valid    = pow_vld_reg[EXP_STEPS-1];
    assign exp_res.item = pow_reg[EXP_STEPS-1].item;
    assign exp_res.e    = pow_reg[EXP_STEPS-1].r;

endmodule

// ===== sv/nau_divlog.sv =====
module nau_divlog
    import nau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     exp_valid,
    input  nau_exp_t exp_res,
    output logic     dl_valid,
    output nau_dl_t  dl_res
);

    typedef struct packed {
        nau_in_t     item;
        logic [30:0] e;
        logic [31:0] d;
        logic [31:0] rem;
        logic [30:0] nlow;
        logic [30:0] q;
        logic [30:0] m;
        logic [29:0] l;
        logic        ip;
    } dl_t;

    dl_t  dl_reg     [DIV_STEPS+1];
    logic dl_vld_reg [DIV_STEPS+1];
    dl_t  setup_next;
    logic [30:0] a;
    logic [60:0] num;

    always_comb
    begin
        setup_next.item = exp_res.item;
        setup_next.e    = exp_res.e;
        setup_next.d    = 32'(exp_res.e) + 32'(ONE30);
        if (exp_res.item.command inside {CMD_TANH, CMD_D_TANH})
            a = ONE30 - exp_res.e;
        else
            a = ONE30;
        num = {a, 30'd0} + 61'(setup_next.d >> 1);
        setup_next.rem  = 32'(num[60:31]);
        setup_next.nlow = num[30:0];
        setup_next.q    = '0;
        setup_next.ip   = setup_next.d[31];
        setup_next.m    = setup_next.d[31] ? setup_next.d[31:1] : setup_next.d[30:0];
        setup_next.l    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dl_vld_reg[0] <= 1'b0;
        else if (en)
            dl_vld_reg[0] <= exp_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dl_reg[0] <= setup_next;
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        dl_t         src;
        dl_t         step_next;
        logic [32:0] rt;
        logic        ge;
        logic [61:0] sq;
        logic [61:0] msum;
        logic [31:0] mr;

        assign src = dl_reg[j];

        always_comb
        begin
            rt   = {src.rem, src.nlow[30]};
            ge   = rt >= {1'b0, src.d};
            sq   = 62'(src.m) * 62'(src.m);
            msum = sq + 62'(ONE30 >> 1);
            mr   = msum[61:30];
            step_next      = src;
            step_next.rem  = ge ? 32'(rt - {1'b0, src.d}) : rt[31:0];
            step_next.q    = {src.q[29:0], ge};
            step_next.nlow = {src.nlow[29:0], 1'b0};
            if (j < LOG_STEPS)
            begin
                step_next.l = {src.l[28:0], mr[31]};
                step_next.m = mr[31] ? mr[31:1] : mr[30:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dl_vld_reg[j+1] <= 1'b0;
            else if (en)
                dl_vld_reg[j+1] <= dl_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dl_reg[j+1] <= step_next;
        end
    end

    assign dl_valid    = dl_vld_reg[DIV_STEPS];
    assign dl_res.item = dl_reg[DIV_STEPS].item;
    assign dl_res.e    = dl_reg[DIV_STEPS].e;
    assign dl_res.q    = dl_reg[DIV_STEPS].q;
    assign dl_res.l    = {dl_reg[DIV_STEPS].ip, dl_reg[DIV_STEPS].l};

endmodule

// ===== sv/nau_back.sv =====
module nau_back
    import nau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        dl_valid,
    input  nau_dl_t     dl_res,
    input  logic [15:0] leak_slope,
    output logic        out_valid,
    output nau_out_t    out_data
);

    localparam int TOQ_SH  = 30 - FRAC_BITS;
    localparam int LEAK_SH = 16 - FRAC_BITS;
    localparam logic signed [35:0] ONE_Q = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] MAX_V = 36'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [35:0] MIN_V = 36'(-(64'sd1 <<< (DATA_WIDTH - 1)));

    typedef struct packed {
        nau_in_t            item;
        logic [30:0]        q;
        logic [61:0]        prod;
        logic signed [32:0] lprod;
    } b1_t;

    typedef struct packed {
        nau_in_t            item;
        logic [30:0]        q;
        logic [31:0]        r1;
        logic signed [32:0] lprod;
    } b2_t;

    typedef struct packed {
        logic signed [35:0] val;
        logic               toq;
        logic               bad;
    } b3_t;

    b1_t      b1_reg, b1_next;
    b2_t      b2_reg, b2_next;
    b3_t      b3_reg, b3_next;
    nau_out_t out_reg, out_next;
    logic     v1_reg, v2_reg, v3_reg, v4_reg;

    logic [30:0] opa;
    logic [30:0] opb;
    logic [61:0] rsum;

    always_comb
    begin
        case (dl_res.item.command)
            CMD_D_SIGMOID, CMD_D_SOFTMAX:
            begin
                opa = dl_res.q;
                opb = ONE30 - dl_res.q;
            end
            CMD_D_TANH:
            begin
                opa = dl_res.q;
                opb = dl_res.q;
            end
            CMD_SOFTPLUS:
            begin
                opa = dl_res.l;
                opb = 31'(LN2_Q30);
            end
            CMD_GAUSS, CMD_D_GAUSS:
            begin
                opa = dl_res.e;
                opb = 31'(INV_SQRT_2PI_Q30);
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
        b1_next.item  = dl_res.item;
        b1_next.q     = dl_res.q;
        b1_next.prod  = 62'(opa) * 62'(opb);
        b1_next.lprod = 33'(dl_res.item.sample) * $signed({17'd0, leak_slope});
    end

    always_comb
    begin
        rsum          = b1_reg.prod + 62'(ONE30 >> 1);
        b2_next.item  = b1_reg.item;
        b2_next.q     = b1_reg.q;
        b2_next.r1    = rsum[61:30];
        b2_next.lprod = b1_reg.lprod;
    end

    logic signed [16:0] sx;
    logic [16:0]        ax;
    logic               neg;
    logic               pos;
    logic [45:0]        gp;
    logic [45:0]        gsum;
    logic [15:0]        gt;
    logic [32:0]        lsum;
    logic [16:0]        lmag;
    logic [16:0]        dleak;
    logic signed [35:0] qv;

    always_comb
    begin
        sx    = 17'(b2_reg.item.sample);
        neg   = sx[16];
        ax    = neg ? 17'(-sx) : 17'(sx);
        pos   = !neg && (sx != '0);
        gp    = 46'(ax) * 46'(b2_reg.r1[28:0]);
        gsum  = gp + 46'(ONE30 >> 1);
        gt    = gsum[45:30];
        lsum  = 33'(-b2_reg.lprod) + (33'd1 << 15);
        lmag  = lsum[32:16];
        dleak = (17'(leak_slope) + (17'd1 << (LEAK_SH - 1))) >> LEAK_SH;
        qv    = 36'(b2_reg.q);
        b3_next.toq = 1'b1;
        b3_next.bad = 1'b0;
        case (b2_reg.item.command)
            CMD_SIGMOID, CMD_SOFTMAX, CMD_D_SOFTPLUS:
                b3_next.val = neg ? 36'(ONE30) - qv : qv;
            CMD_D_SIGMOID, CMD_D_SOFTMAX, CMD_GAUSS:
                b3_next.val = 36'(b2_reg.r1);
            CMD_TANH:
                b3_next.val = neg ? -qv : qv;
            CMD_D_TANH:
                b3_next.val = 36'(ONE30) - 36'(b2_reg.r1);
            CMD_SOFTPLUS:
                b3_next.val = (neg ? 36'sd0 : (36'(ax) << TOQ_SH)) + 36'(b2_reg.r1);
            CMD_RELU:
            begin
                b3_next.val = neg ? 36'sd0 : 36'(sx);
                b3_next.toq = 1'b0;
            end
            CMD_D_RELU:
            begin
                b3_next.val = neg ? 36'sd0 : ONE_Q;
                b3_next.toq = 1'b0;
            end
            CMD_LEAKY:
            begin
                b3_next.val = pos ? 36'(sx) : -36'(lmag);
                b3_next.toq = 1'b0;
            end
            CMD_D_LEAKY:
            begin
                b3_next.val = pos ? ONE_Q : 36'(dleak);
                b3_next.toq = 1'b0;
            end
            CMD_D_GAUSS:
            begin
                b3_next.val = neg ? 36'(gt) : -36'(gt);
                b3_next.toq = 1'b0;
            end
            default:
            begin
                b3_next.val = '0;
                b3_next.toq = 1'b0;
                b3_next.bad = 1'b1;
            end
        endcase
    end

    logic [35:0]        mag;
    logic [35:0]        mrnd;
    logic signed [35:0] v;

    always_comb
    begin
        mag  = b3_reg.val[35] ? 36'(-b3_reg.val) : 36'(b3_reg.val);
        mrnd = (mag + (36'd1 << (TOQ_SH - 1))) >> TOQ_SH;
        if (b3_reg.toq)
            v = b3_reg.val[35] ? -$signed(mrnd) : $signed(mrnd);
        else
            v = b3_reg.val;
        if (v > MAX_V)
            v = MAX_V;
        if (v < MIN_V)
            v = MIN_V;
        out_next.result      = v[DATA_WIDTH-1:0];
        out_next.bad_command = b3_reg.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= dl_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/neural_activation_unit.sv =====
// Activation function unit, one Q4.12 sample and a 4-bit command per beat.
// Input channel in_valid/in_ready/in_data carries {command, sample}; output
// channel out_valid/out_ready/out_data carries {result, bad_command}.
// cfg_we/cfg_data write the leaky ReLU slope (unsigned Q0.16); write it only
// while no beat is in flight.
// Throughput: one beat per cycle unless the receiver stalls, set by the fully
// pipelined datapath (39 Taylor stages for e^-x, 31 multiply-by-1/e stages,
// 31 divide/log2 bit stages, setup and post stages).
// Reset clears all valid bits and loads the slope with 655 (about 0.01).
// When the receiver stalls the whole pipeline holds; in_ready drops with it
// and rises again when the output beat is taken. Commands 14 and 15 return
// zero with bad_command set.
module neural_activation_unit
    import nau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  nau_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output nau_out_t    out_data,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    logic        en;
    logic [15:0] leak_reg;
    logic        arg_valid;
    nau_arg_t    arg;
    logic        exp_valid;
    nau_exp_t    exp_res;
    logic        dl_valid;
    nau_dl_t     dl_res;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            leak_reg <= 16'd655;
        else if (cfg_we)
            leak_reg <= cfg_data;
    end

    nau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_data),
        .arg_valid (arg_valid),
        .arg       (arg)
    );

    nau_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .arg_valid (arg_valid),
        .arg       (arg),
        .exp_valid (exp_valid),
        .exp_res   (exp_res)
    );

    nau_divlog u_divlog (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .exp_valid (exp_valid),
        .exp_res   (exp_res),
        .dl_valid  (dl_valid),
        .dl_res    (dl_res)
    );

    nau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .dl_valid   (dl_valid),
        .dl_res     (dl_res),
        .leak_slope (leak_reg),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output");
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_command |-> out_data.result == '0)
        else $error("invalid command with nonzero result");
`endif

endmodule
